// ===== rtl/lfa_pkg.sv =====
// Shared types and constants of the lazy-init free-list slot allocator.
// No dependencies.
`timescale 1ns / 1ps

package lfa_pkg;

	localparam int SLOT_DEPTH = 256;
	localparam int SLOT_W     = 8;
	localparam int CNT_W      = 9;
	localparam int POOL_MAX   = (SLOT_DEPTH < 256) ? SLOT_DEPTH : 256;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  count_t;

	typedef enum logic [1:0] {
		ST_GRANTED  = 2'd0,
		ST_RELEASED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BAD_REL  = 2'd3
	} status_t;

	typedef enum logic {
		ACT_ALLOC   = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	localparam logic [2:0] ADDR_POOL_COUNT = 3'd0;

endpackage

// ===== rtl/lazy_init_free_list_allocator_top.sv =====
// Fixed-size slot allocator with a lazily initialised linked free list.
// Depends on lfa_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_stall): one word per request, action 0 asks for
//   a slot, action 1 hands release_index back. Output channel
//   (out_valid/out_stall): one word per request with status, slot_index and
//   the free slot count after the request.
//   The result word is registered and appears the cycle after acceptance.
//   An allocate that pops the list and leaves slots free goes to S_FETCH: the
//   next-slot link of the old head is read from the single-port-read link
//   memory (registered read) and loaded into the head before the next
//   request. Releases, empty, last-slot and rejected requests need no fetch.
//   While the result register is full and out_stall is high, in_stall is
//   raised; a pending word holds until taken.
//   Reset: pool_count 256, head 0, full pool, nothing initialised. The link
//   memory is not cleared; links are written lazily, one per allocate up to pool_count.
//   Writing pool_count over APB (address 0) clamps it to 1..256 and restarts
//   the pool. Writes are expected only while the block is idle.
module lazy_init_free_list_allocator_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [7:0]           release_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [7:0]           slot_index,
	output logic [8:0]           free_slots,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import lfa_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_FETCH
	} state_t;

	state_t  state_q;
	count_t  pool_q;
	count_t  free_q;
	count_t  init_q;
	slot_t   head_q;
	logic    head_valid_q;
	logic    fwd_s1;
	slot_t   fwd_val_s1;
	count_t  rdata_s1;
	logic    out_valid_q;
	status_t status_q;
	slot_t   slot_q;
	count_t  free_out_q;

	count_t  link_mem [SLOT_DEPTH];

	logic    acc;
	logic    is_alloc;
	logic    lazy;
	logic    pop;
	logic    last;
	logic    rel_ok;
	logic    we;
	slot_t   waddr;
	count_t  wdata;
	logic    cfg_we;
	count_t  cfg_val;
	count_t  init_inc;

	assign pready   = 1'b1;
	assign in_stall = (state_q == S_FETCH) || (out_valid_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign is_alloc = (action == ACT_ALLOC);
	assign lazy     = is_alloc && (init_q < pool_q);
	assign pop      = is_alloc && (free_q != '0);
	assign last     = pop && (free_q == count_t'(1));
	assign rel_ok   = !is_alloc && ({1'b0, release_index} < pool_q) && (free_q < pool_q);
	assign init_inc = count_t'(init_q + 1'b1);

	assign we    = acc && (lazy || rel_ok);
	assign waddr = lazy ? init_q[SLOT_W-1:0] : release_index;
	assign wdata = lazy ? init_inc : (head_valid_q ? {1'b0, head_q} : pool_q);

	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == ADDR_POOL_COUNT[2]);

	always_comb begin
		cfg_val = pwdata[CNT_W-1:0];
		if (cfg_val == '0) begin
			cfg_val = count_t'(1);
		end else if (cfg_val > count_t'(POOL_MAX)) begin
			cfg_val = count_t'(POOL_MAX);
		end
	end

	assign prdata = (paddr[2] == ADDR_POOL_COUNT[2]) ? {{(32-CNT_W){1'b0}}, pool_q} : '0;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_index = slot_q;
	assign free_slots = free_out_q;

	// link memory: one write, one registered read at the current head
	always_ff @(posedge clk) begin
		if (we) begin
			link_mem[waddr] <= wdata;
		end
		rdata_s1 <= link_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pool_q       <= count_t'(POOL_MAX);
			free_q       <= count_t'(POOL_MAX);
			init_q       <= '0;
			head_q       <= '0;
			head_valid_q <= 1'b1;
			fwd_s1       <= 1'b0;
			fwd_val_s1   <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_GRANTED;
			slot_q       <= '0;
			free_out_q   <= '0;
		end else begin
			if (state_q == S_FETCH) begin
				head_q  <= fwd_s1 ? fwd_val_s1 : rdata_s1[SLOT_W-1:0];
				state_q <= S_IDLE;
			end

			if (acc) begin
				out_valid_q <= 1'b1;
				if (lazy) begin
					init_q <= init_inc;
				end
				if (is_alloc) begin
					if (pop) begin
						status_q   <= ST_GRANTED;
						slot_q     <= head_q;
						free_q     <= count_t'(free_q - 1'b1);
						free_out_q <= count_t'(free_q - 1'b1);
						if (last) begin
							head_valid_q <= 1'b0;
							head_q       <= '0;
						end else begin
							state_q    <= S_FETCH;
							fwd_s1     <= lazy && (init_q[SLOT_W-1:0] == head_q);
							fwd_val_s1 <= init_inc[SLOT_W-1:0];
						end
					end else begin
						status_q   <= ST_EMPTY;
						slot_q     <= '0;
						free_out_q <= free_q;
					end
				end else if (rel_ok) begin
					status_q     <= ST_RELEASED;
					slot_q       <= '0;
					head_q       <= release_index;
					head_valid_q <= 1'b1;
					free_q       <= count_t'(free_q + 1'b1);
					free_out_q   <= count_t'(free_q + 1'b1);
				end else begin
					status_q   <= ST_BAD_REL;
					slot_q     <= '0;
					free_out_q <= free_q;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// pool restart wins over any pending head fetch
			if (cfg_we) begin
				pool_q       <= cfg_val;
				free_q       <= cfg_val;
				init_q       <= '0;
				head_q       <= '0;
				head_valid_q <= 1'b1;
				state_q      <= S_IDLE;
			end
		end
	end

	a_fetch_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> in_stall)
		else $error("request accepted during head fetch");

	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= pool_q)
		else $error("free count above pool size");

	a_init_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		init_q <= pool_q)
		else $error("init count above pool size");

	a_head_valid_free: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid_q == (free_q != '0))
		else $error("head valid disagrees with free count");

	a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |=> (state_q == S_IDLE))
		else $error("head fetch longer than one cycle");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the lazy-init free-list slot allocator.
// Directed table then random phases, checked against an in-bench predictor.
// Depends on lfa_pkg and lazy_init_free_list_allocator_top.
`timescale 1ns / 1ps

module testbench;
	import lfa_pkg::*;

	typedef struct packed {
		status_t st;
		slot_t   slot;
		count_t  nfree;
	} reply_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		action_t     act;
		slot_t       idx;
		logic [31:0] cfg;
		logic        typed;
		reply_t      want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [7:0]  release_index;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  slot_index;
	logic [8:0]  free_slots;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predictor state
	count_t next_link [SLOT_DEPTH];
	bit     link_known [SLOT_DEPTH];
	bit     in_use [SLOT_DEPTH];
	slot_t  free_head;
	bit     head_live;
	count_t free_cnt;
	count_t seeded;
	count_t pool_slots;

	reply_t due_replies [$];
	row_t   plan [$];
	int     errors;
	bit     calm;

	lazy_init_free_list_allocator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.release_index(release_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.slot_index   (slot_index),
		.free_slots   (free_slots),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void restart_pool(logic [31:0] raw);
		count_t v;
		v = raw[8:0];
		if (v == 0) v = count_t'(1);
		if (v > POOL_MAX) v = count_t'(POOL_MAX);
		pool_slots = v;
		free_head = '0;
		head_live = 1'b1;
		free_cnt = v;
		seeded = '0;
		for (int k = 0; k < SLOT_DEPTH; k++) in_use[k] = 1'b0;
	endfunction

	function automatic reply_t apply_request(action_t a, slot_t idx);
		reply_t r;
		r = '{ST_GRANTED, 8'd0, 9'd0};
		if (a == ACT_ALLOC) begin
			if (seeded < pool_slots) begin
				next_link[seeded[7:0]] = seeded + 1'b1;
				link_known[seeded[7:0]] = 1'b1;
				seeded = seeded + 1'b1;
			end
			if (free_cnt != 0) begin
				r.slot = free_head;
				in_use[free_head] = 1'b1;
				free_cnt = free_cnt - 1'b1;
				if (free_cnt != 0) begin
					free_head = next_link[free_head][7:0];
				end else begin
					head_live = 1'b0;
					free_head = '0;
				end
				r.st = ST_GRANTED;
			end else begin
				r.st = ST_EMPTY;
			end
		end else if ({1'b0, idx} >= pool_slots || free_cnt >= pool_slots) begin
			r.st = ST_BAD_REL;
		end else begin
			next_link[idx] = head_live ? {1'b0, free_head} : pool_slots;
			link_known[idx] = 1'b1;
			in_use[idx] = 1'b0;
			free_head = idx;
			head_live = 1'b1;
			free_cnt = free_cnt + 1'b1;
			r.st = ST_RELEASED;
		end
		r.nfree = free_cnt;
		return r;
	endfunction

	// a pop that would follow a link never written since reset
	function automatic bit pop_hits_blank();
		if (free_cnt <= 1) return 1'b0;
		if (seeded < pool_slots && seeded[7:0] == free_head) return 1'b0;
		return !link_known[free_head];
	endfunction

	function automatic bit pick_held(output slot_t s);
		int    start;
		slot_t c;
		start = $urandom_range(255);
		s = '0;
		for (int k = 0; k < SLOT_DEPTH; k++) begin
			c = slot_t'(start + k);
			if (in_use[c] && {1'b0, c} < pool_slots) begin
				s = c;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic issue(action_t a, slot_t idx, logic typed, reply_t want);
		reply_t got;
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		release_index <= idx;
		do @(posedge clk); while (in_stall);
		got = apply_request(a, idx);
		due_replies.push_back(typed ? want : got);
	endtask

	// drain, then let a trailing link load settle
	task automatic quiesce();
		in_valid <= 1'b0;
		while (due_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic pool_write(logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_POOL_COUNT;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		restart_pool(v);
	endtask

	always @(posedge clk) begin
		reply_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (due_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: status %0d slot %0d free %0d",
					$time, status, slot_index, free_slots);
			end else begin
				w = due_replies.pop_front();
				if (status !== w.st || slot_index !== w.slot || free_slots !== w.nfree) begin
					errors++;
					$display("%0t: expected status %0d slot %0d free %0d, got %0d %0d %0d",
						$time, w.st, w.slot, w.nfree, status, slot_index, free_slots);
				end
			end
		end
	end

	// sink side, with one long hold-off to back the block up
	initial begin
		int taken;
		bit held;
		taken = 0;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) taken++;
			if (!held && taken >= 120 && in_valid) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 36);
			end
		end
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int          rand_sent;
		int          bias;
		int          span;
		logic [31:0] cfg;
		action_t     a;
		slot_t       idx;
		reply_t      none;

		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_ALLOC;
		release_index = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		calm = 1'b0;
		rand_sent = 0;
		none = '{ST_GRANTED, 8'd0, 9'd0};
		for (int k = 0; k < SLOT_DEPTH; k++) begin
			next_link[k] = '0;
			link_known[k] = 1'b0;
		end
		restart_pool(32'd256);

		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd0,   32'd0, 1'b1, '{ST_BAD_REL, 8'd0, 9'd256}});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b1, '{ST_GRANTED, 8'd0, 9'd255}});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b1, '{ST_GRANTED, 8'd1, 9'd254}});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd255, 32'd0, 1'b1, '{ST_RELEASED, 8'd0, 9'd255}});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b0, none});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd0,   32'd0, 1'b0, none});
		// zero pool count is taken as one
		plan.push_back('{ROW_CFG, ACT_ALLOC,   8'd0,   32'd0, 1'b0, none});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b1, '{ST_GRANTED, 8'd0, 9'd0}});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b1, '{ST_EMPTY, 8'd0, 9'd0}});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd255, 32'd0, 1'b1, '{ST_BAD_REL, 8'd0, 9'd0}});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd0,   32'd0, 1'b1, '{ST_RELEASED, 8'd0, 9'd1}});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd0,   32'd0, 1'b1, '{ST_BAD_REL, 8'd0, 9'd1}});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b1, '{ST_GRANTED, 8'd0, 9'd0}});
		// oversize count clamps to the full pool
		plan.push_back('{ROW_CFG, ACT_ALLOC,   8'd0,   32'h1FF, 1'b0, none});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b1, '{ST_GRANTED, 8'd0, 9'd255}});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd128, 32'd0, 1'b1, '{ST_RELEASED, 8'd0, 9'd256}});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd128, 32'd0, 1'b1, '{ST_BAD_REL, 8'd0, 9'd256}});
		// double release corrupts the list into a self loop
		plan.push_back('{ROW_CFG, ACT_ALLOC,   8'd0,   32'd4, 1'b0, none});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b1, '{ST_GRANTED, 8'd0, 9'd3}});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b1, '{ST_GRANTED, 8'd1, 9'd2}});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd1,   32'd0, 1'b1, '{ST_RELEASED, 8'd0, 9'd3}});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd1,   32'd0, 1'b1, '{ST_RELEASED, 8'd0, 9'd4}});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b0, none});
		plan.push_back('{ROW_REQ, ACT_ALLOC,   8'd0,   32'd0, 1'b0, none});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd4,   32'd0, 1'b1, '{ST_BAD_REL, 8'd0, 9'd2}});
		plan.push_back('{ROW_REQ, ACT_RELEASE, 8'd3,   32'd0, 1'b0, none});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				quiesce();
				pool_write(plan[i].cfg);
			end else begin
				issue(plan[i].act, plan[i].idx, plan[i].typed, plan[i].want);
			end
		end

		while (rand_sent < 450) begin
			quiesce();
			case ($urandom_range(7))
				0: cfg = 32'd256;
				1: cfg = $urandom();
				2: cfg = 32'd0;
				default: cfg = $urandom_range(2, 24);
			endcase
			pool_write(cfg);
			bias = $urandom_range(35, 70);
			span = $urandom_range(30, 90);
			for (int n = 0; n < span; n++) begin
				if ($urandom_range(99) < bias) begin
					// a corrupted list may lead off the written links: start afresh
					if (pop_hits_blank()) break;
					a = ACT_ALLOC;
					idx = slot_t'($urandom_range(255));
				end else begin
					a = ACT_RELEASE;
					if ($urandom_range(9) < 2 || !pick_held(idx)) idx = slot_t'($urandom_range(255));
				end
				calm = (rand_sent >= 200 && rand_sent < 280);
				issue(a, idx, 1'b0, none);
				rand_sent++;
			end
		end
		calm = 1'b0;

		quiesce();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
